// ----- rtl/core/gts_pkg.sv -----
package gts_pkg;

    // coordinate and radius formats
    localparam int COORD_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int RADIUS_W      = 31;
    localparam int MAG_W         = COORD_W;
    // radicand and remainder width, sqrt and divide step counts
    localparam int SQ_W          = 64;
    localparam int SQ_STEPS      = 32;
    localparam int DIV_STEPS     = RADIUS_W;
    localparam int PROD_W        = 62;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] v_x;
        logic signed [COORD_W-1:0] v_y;
        logic signed [COORD_W-1:0] v_z;
        logic        [1:0]         child_index;
    } t_tri_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_a_x;
        logic signed [COORD_W-1:0] out_a_y;
        logic signed [COORD_W-1:0] out_a_z;
        logic signed [COORD_W-1:0] out_b_x;
        logic signed [COORD_W-1:0] out_b_y;
        logic signed [COORD_W-1:0] out_b_z;
        logic signed [COORD_W-1:0] out_v_x;
        logic signed [COORD_W-1:0] out_v_y;
        logic signed [COORD_W-1:0] out_v_z;
    } t_tri_out;

    typedef enum logic [1:0] {
        CHILD_A   = 2'd0,
        CHILD_B   = 2'd1,
        CHILD_V   = 2'd2,
        CHILD_MID = 2'd3
    } t_child;

    // one step of the integer square root
    typedef struct packed {
        logic [SQ_W-1:0] x;
        logic [SQ_W-1:0] r;
    } t_sq_word;

    // one step of the restoring divide
    typedef struct packed {
        logic [SQ_W-1:0]      rem;
        logic [MAG_W-1:0]     dvs;
        logic [DIV_STEPS-1:0] q;
    } t_dv_word;

    // data riding alongside the divide chain
    typedef struct packed {
        t_tri_in    vert;
        logic [8:0] neg;
        logic [2:0] zero;
    } t_side_dv;

    // data riding alongside the sqrt chain
    typedef struct packed {
        t_side_dv              base;
        logic [8:0][PROD_W-1:0] prod;
    } t_side_sq;

endpackage

// ----- rtl/core/gts_sqrt_cell.sv -----
module gts_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  gts_pkg::t_sq_word i_word,
    output gts_pkg::t_sq_word o_word
);
    import gts_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

    t_sq_word        r_word;
    t_sq_word        n_word;
    logic [SQ_W-1:0] trial;

    // digit-by-digit root: try the next result bit
    always_comb begin
        trial  = i_word.r + BIT;
        n_word = i_word;
        if (i_word.x >= trial) begin
            n_word.x = i_word.x - trial;
            n_word.r = (i_word.r >> 1) + BIT;
        end else begin
            n_word.r = i_word.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ----- rtl/core/gts_div_cell.sv -----
module gts_div_cell #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  gts_pkg::t_dv_word i_word,
    output gts_pkg::t_dv_word o_word
);
    import gts_pkg::*;

    localparam int SH = DIV_STEPS - 1 - STEP;

    t_dv_word        r_word;
    t_dv_word        n_word;
    logic [SQ_W-1:0] shifted;

    // restoring step: one quotient bit, msb first
    always_comb begin
        shifted = SQ_W'(i_word.dvs) << SH;
        n_word  = i_word;
        if (i_word.rem >= shifted) begin
            n_word.rem   = i_word.rem - shifted;
            n_word.q[SH] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ----- rtl/core/geodesic_triangle_subdivide_top.sv -----
// Geodesic triangle subdivision.
// Input channel: i_valid / o_stall with one triangle word (three vertices and
// a child index) in i_data; a word is taken when i_valid is high and o_stall
// low. Output channel: o_valid / i_stall with the child triangle in o_data.
// Config channel: i_cfg_valid / o_cfg_ready writes the sphere radius; ready
// is always high. Write it only while no triangle is in flight.
// Throughput: one triangle per cycle while o_stall is low. From the accepting
// edge to o_valid a word passes four front stages (midpoint, magnitude,
// squares, sum), 32 root cells, 31 divide cells, a select stage and the
// output register. Each midpoint lane has its own root chain and each
// coordinate its own divide chain, so nothing is shared between words.
// Reset clears all valid flags and sets the radius to 1.0.
// When the receiver stalls, one more word lands in a skid register; the
// whole pipeline then holds and o_stall rises until the skid drains.
module geodesic_triangle_subdivide_top #(
    parameter int FRAC_BITS = gts_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  gts_pkg::t_tri_in             i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output gts_pkg::t_tri_out            o_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gts_pkg::RADIUS_W-1:0] i_cfg_data
);
    import gts_pkg::*;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(64'(1) << FRAC_BITS);

    logic                en;
    logic [RADIUS_W-1:0] r_radius;

    // front stage registers
    logic                      r_v1, r_v2, r_v3, r_v4;
    t_tri_in                   r_t1, r_t2, r_t3, r_t4;
    logic signed [COORD_W-1:0] r_mid [3][3];
    logic [MAG_W-1:0]          r_mag [3][3];
    logic [8:0]                r_neg2, r_neg3, r_neg4;
    logic [SQ_W-1:0]           r_sq  [3][3];
    logic [PROD_W-1:0]         r_prod3 [9];
    logic [PROD_W-1:0]         r_prod4 [9];
    logic [SQ_W-1:0]           r_sum [3];

    logic signed [COORD_W-1:0] vin [3][3];

    // chains
    t_sq_word         w_sq [3][SQ_STEPS+1];
    t_dv_word         w_dv [9][DIV_STEPS+1];
    t_side_sq         r_side_sq [SQ_STEPS];
    t_side_dv         r_side_dv [DIV_STEPS];
    logic [SQ_STEPS-1:0]  r_vld_sq;
    logic [DIV_STEPS-1:0] r_vld_dv;

    // select and output stages
    logic                      r_p_v, r_out_v, r_skid_v;
    t_tri_out                  r_p, r_out, r_skid, n_p;
    logic signed [COORD_W-1:0] pt [3][3];
    logic signed [COORD_W-1:0] corner [3][3];
    logic                      take;

    assign en          = !r_skid_v;
    assign o_stall     = r_skid_v;
    assign o_valid     = r_out_v;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;
    assign take        = r_out_v && !i_stall;

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    assign vin[0] = '{i_data.a_x, i_data.a_y, i_data.a_z};
    assign vin[1] = '{i_data.b_x, i_data.b_y, i_data.b_z};
    assign vin[2] = '{i_data.v_x, i_data.v_y, i_data.v_z};

    // front valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // midpoints ab, av, bv: floor of the half sum; then magnitude, squares, sum
    always_ff @(posedge i_clk) begin
        logic signed [COORD_W:0] s;
        if (en) begin
            r_t1 <= i_data;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
            for (int c = 0; c < 3; c++) begin
                s = {vin[0][c][COORD_W-1], vin[0][c]} + {vin[1][c][COORD_W-1], vin[1][c]};
                r_mid[0][c] <= s[COORD_W:1];
                s = {vin[0][c][COORD_W-1], vin[0][c]} + {vin[2][c][COORD_W-1], vin[2][c]};
                r_mid[1][c] <= s[COORD_W:1];
                s = {vin[1][c][COORD_W-1], vin[1][c]} + {vin[2][c][COORD_W-1], vin[2][c]};
                r_mid[2][c] <= s[COORD_W:1];
            end
            for (int m = 0; m < 3; m++) begin
                for (int c = 0; c < 3; c++) begin
                    r_neg2[m*3+c] <= r_mid[m][c][COORD_W-1];
                    r_mag[m][c]   <= r_mid[m][c][COORD_W-1] ? (~r_mid[m][c] + 1'b1)
                                                            : r_mid[m][c];
                    r_sq[m][c]      <= SQ_W'(r_mag[m][c]) * SQ_W'(r_mag[m][c]);
                    r_prod3[m*3+c]  <= PROD_W'(SQ_W'(r_mag[m][c]) * SQ_W'(r_radius));
                    r_prod4[m*3+c]  <= r_prod3[m*3+c];
                end
                r_sum[m] <= r_sq[m][0] + r_sq[m][1] + r_sq[m][2];
            end
            r_neg3 <= r_neg2;
            r_neg4 <= r_neg3;
        end
    end

    // sqrt chains, one per midpoint
    for (genvar m = 0; m < 3; m++) begin : g_sq
        assign w_sq[m][0] = '{x: r_sum[m], r: '0};
        for (genvar s = 0; s < SQ_STEPS; s++) begin : g_cell
            gts_sqrt_cell #(.STEP(s)) u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_word (w_sq[m][s]),
                .o_word (w_sq[m][s+1])
            );
        end
    end

    // divide chains, one per coordinate
    for (genvar l = 0; l < 9; l++) begin : g_dv
        assign w_dv[l][0] = '{rem: SQ_W'(r_side_sq[SQ_STEPS-1].prod[l]),
                              dvs: w_sq[l/3][SQ_STEPS].r[MAG_W-1:0],
                              q:   '0};
        for (genvar s = 0; s < DIV_STEPS; s++) begin : g_cell
            gts_div_cell #(.STEP(s)) u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_word (w_dv[l][s]),
                .o_word (w_dv[l][s+1])
            );
        end
    end

    // side data alongside the chains
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_sq[0].base.vert <= r_t4;
            r_side_sq[0].base.neg  <= r_neg4;
            for (int m = 0; m < 3; m++) begin
                r_side_sq[0].base.zero[m] <= (r_sum[m] == '0);
            end
            for (int l = 0; l < 9; l++) begin
                r_side_sq[0].prod[l] <= r_prod4[l];
            end
            for (int s = 1; s < SQ_STEPS; s++) begin
                r_side_sq[s] <= r_side_sq[s-1];
            end
            r_side_dv[0] <= r_side_sq[SQ_STEPS-1].base;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_side_dv[s] <= r_side_dv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sq <= '0;
            r_vld_dv <= '0;
        end else if (en) begin
            r_vld_sq <= {r_vld_sq[SQ_STEPS-2:0], r_v4};
            r_vld_dv <= {r_vld_dv[DIV_STEPS-2:0], r_vld_sq[SQ_STEPS-1]};
        end
    end

    // signed projected points; the quotient never exceeds the radius,
    // which already fits the coordinate range
    always_comb begin
        logic signed [COORD_W-1:0] q;
        t_side_dv sd;
        sd = r_side_dv[DIV_STEPS-1];
        for (int m = 0; m < 3; m++) begin
            for (int c = 0; c < 3; c++) begin
                q = COORD_W'(w_dv[m*3+c][DIV_STEPS].q);
                if (sd.zero[m]) begin
                    pt[m][c] = '0;
                end else begin
                    pt[m][c] = sd.neg[m*3+c] ? -q : q;
                end
            end
        end
        corner[0] = '{sd.vert.a_x, sd.vert.a_y, sd.vert.a_z};
        corner[1] = '{sd.vert.b_x, sd.vert.b_y, sd.vert.b_z};
        corner[2] = '{sd.vert.v_x, sd.vert.v_y, sd.vert.v_z};
    end

    // child selection
    always_comb begin
        logic signed [COORD_W-1:0] s0 [3];
        logic signed [COORD_W-1:0] s1 [3];
        logic signed [COORD_W-1:0] s2 [3];
        unique case (t_child'(r_side_dv[DIV_STEPS-1].vert.child_index))
            CHILD_A: begin
                s0 = pt[0]; s1 = corner[0]; s2 = pt[1];
            end
            CHILD_B: begin
                s0 = pt[0]; s1 = pt[2]; s2 = corner[1];
            end
            CHILD_V: begin
                s0 = pt[1]; s1 = corner[2]; s2 = pt[2];
            end
            default: begin
                s0 = pt[0]; s1 = pt[1]; s2 = pt[2];
            end
        endcase
        n_p = '{s0[0], s0[1], s0[2], s1[0], s1[1], s1[2], s2[0], s2[1], s2[2]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v    <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (en) begin
                r_p_v <= r_vld_dv[DIV_STEPS-1];
            end
            if (r_skid_v) begin
                if (take || !r_out_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end
            end else if (r_p_v) begin
                if (!r_out_v || take) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take || !r_out_v) begin
                r_out <= r_skid;
            end
        end else if (r_p_v) begin
            if (!r_out_v || take) begin
                r_out <= r_p;
            end else begin
                r_skid <= r_p;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a word while the output register is empty");

    a_root_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_sq[SQ_STEPS-1] |-> (w_sq[0][SQ_STEPS].r[SQ_W-1:MAG_W] == '0))
        else $error("square root wider than the divisor");

    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_dv[DIV_STEPS-1] && !r_side_dv[DIV_STEPS-1].zero[0])
        |-> (w_dv[0][DIV_STEPS].rem < SQ_W'(w_dv[0][DIV_STEPS].dvs)))
        else $error("divide remainder not below divisor");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output not idle after reset");
`endif

endmodule
